>>> rtl/gac_pkg.sv
// Package for the gas alarm controller: codes, config/state/result structs, helpers.
// No dependencies; used by gac_step, gas_alarm_controller and the testbench.
`timescale 1ns / 1ps

package gac_pkg;

  localparam logic [31:0] CLEAR_AIR_MS = 32'd30000;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_SILENCE = 2'd1,
    OP_TEST    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BUZ_NONE  = 2'd0,
    BUZ_OFF   = 2'd1,
    BUZ_ALARM = 2'd2,
    BUZ_TEST  = 2'd3
  } buz_e;

  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_WARNING  = 5'b00010,
    MODE_ACTIVE   = 5'b00100,
    MODE_SILENCED = 5'b01000,
    MODE_TEST     = 5'b10000
  } mode_e;

  typedef enum logic [2:0] {
    CFG_CO_CRITICAL  = 3'd0,
    CFG_CO_ALARM     = 3'd1,
    CFG_CO_WARNING   = 3'd2,
    CFG_VOC_ALARM    = 3'd3,
    CFG_VOC_RISE     = 3'd4,
    CFG_DEBOUNCE     = 3'd5,
    CFG_HUSH_TIME    = 3'd6,
    CFG_TEST_TIME    = 3'd7
  } cfg_idx_e;

  localparam logic [2:0] CODE_IDLE     = 3'd0;
  localparam logic [2:0] CODE_WARNING  = 3'd1;
  localparam logic [2:0] CODE_ACTIVE   = 3'd2;
  localparam logic [2:0] CODE_SILENCED = 3'd3;
  localparam logic [2:0] CODE_TEST     = 3'd4;

  typedef struct packed {
    logic [15:0] co_critical_level;
    logic [15:0] co_alarm_level;
    logic [15:0] co_warning_level;
    logic [8:0]  voc_alarm_level;
    logic [8:0]  voc_rise_limit;
    logic [7:0]  debounce_count;
    logic [31:0] hush_time_ms;
    logic [31:0] test_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [15:0] co_level;
    logic [8:0]  voc_level;
    logic [8:0]  voc_previous;
    logic        buzzer_finished;
  } item_t;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  confirm_counter;
    logic [7:0]  clear_counter;
    logic [31:0] alarm_time;
    logic [31:0] hush_time;
    logic [31:0] test_time;
  } ctx_t;

  typedef struct packed {
    logic [2:0] alarm_mode;
    logic       mode_changed;
    buz_e       buzzer_command;
    logic       alarm_sounding;
  } res_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c < COUNT_MAX) ? c + 8'd1 : COUNT_MAX;
  endfunction

  function automatic logic [2:0] mode_code(input mode_e m);
    logic [2:0] code;
    case (m)
      MODE_IDLE:     code = CODE_IDLE;
      MODE_WARNING:  code = CODE_WARNING;
      MODE_ACTIVE:   code = CODE_ACTIVE;
      MODE_SILENCED: code = CODE_SILENCED;
      MODE_TEST:     code = CODE_TEST;
      default:       code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/gac_in_if.sv
// Input channel of the gas alarm controller: valid/ready plus one input item.
// Depends on nothing; fields match gac_pkg::item_t.
`timescale 1ns / 1ps

interface gac_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_ms;
  logic [15:0] co_level;
  logic [8:0]  voc_level;
  logic [8:0]  voc_previous;
  logic        buzzer_finished;

  modport source(output valid, operation, now_ms, co_level, voc_level, voc_previous,
                 buzzer_finished, input ready);
  modport sink(input valid, operation, now_ms, co_level, voc_level, voc_previous,
               buzzer_finished, output ready);
endinterface

>>> rtl/gac_out_if.sv
// Result channel of the gas alarm controller: valid/ready plus one result item.
// Depends on nothing; fields match gac_pkg::res_t.
`timescale 1ns / 1ps

interface gac_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] alarm_mode;
  logic       mode_changed;
  logic [1:0] buzzer_command;
  logic       alarm_sounding;

  modport source(output valid, alarm_mode, mode_changed, buzzer_command, alarm_sounding,
                 input ready);
  modport sink(input valid, alarm_mode, mode_changed, buzzer_command, alarm_sounding,
               output ready);
endinterface

>>> rtl/gac_step.sv
// Next-state and result logic of the alarm state machine for one transaction.
// Depends on gac_pkg.
`timescale 1ns / 1ps

module gac_step (
  input  gac_pkg::cfg_t  cfg_i,
  input  gac_pkg::ctx_t  ctx_i,
  input  gac_pkg::item_t item_i,
  output gac_pkg::ctx_t  ctx_o,
  output gac_pkg::res_t  res_o
);

  logic        crit;
  logic        warn;
  logic        dang;
  logic [8:0]  voc_rise;
  logic [31:0] since_alarm;
  logic [31:0] since_hush;
  logic [31:0] since_test;
  logic [7:0]  confirm_inc;
  logic [7:0]  clear_inc;
  gac_pkg::buz_e buz;

  assign crit        = item_i.co_level >= cfg_i.co_critical_level;
  assign warn        = item_i.co_level >= cfg_i.co_warning_level;
  assign voc_rise    = item_i.voc_level - item_i.voc_previous;
  assign dang        = crit || (item_i.co_level >= cfg_i.co_alarm_level) ||
                       (item_i.voc_level >= cfg_i.voc_alarm_level) ||
                       ((item_i.voc_level >= item_i.voc_previous) &&
                        (voc_rise >= cfg_i.voc_rise_limit));
  assign since_alarm = item_i.now_ms - ctx_i.alarm_time;
  assign since_hush  = item_i.now_ms - ctx_i.hush_time;
  assign since_test  = item_i.now_ms - ctx_i.test_time;
  assign confirm_inc = gac_pkg::sat_inc(ctx_i.confirm_counter);
  assign clear_inc   = gac_pkg::sat_inc(ctx_i.clear_counter);

  always_comb begin
    ctx_o = ctx_i;
    buz   = gac_pkg::BUZ_NONE;
    case (gac_pkg::op_e'(item_i.operation))
      gac_pkg::OP_SAMPLE: begin
        case (ctx_i.mode)
          gac_pkg::MODE_IDLE, gac_pkg::MODE_WARNING: begin
            if (dang) begin
              ctx_o.clear_counter = 8'd0;
              if (crit || (confirm_inc >= cfg_i.debounce_count)) begin
                ctx_o.mode            = gac_pkg::MODE_ACTIVE;
                ctx_o.alarm_time      = item_i.now_ms;
                ctx_o.confirm_counter = 8'd0;
              end else begin
                ctx_o.confirm_counter = confirm_inc;
                if (warn) begin
                  ctx_o.mode = gac_pkg::MODE_WARNING;
                end
              end
            end else begin
              ctx_o.confirm_counter = 8'd0;
              if (ctx_i.mode == gac_pkg::MODE_WARNING) begin
                if (clear_inc >= cfg_i.debounce_count) begin
                  ctx_o.mode          = gac_pkg::MODE_IDLE;
                  ctx_o.clear_counter = 8'd0;
                end else begin
                  ctx_o.clear_counter = clear_inc;
                end
              end
            end
          end
          gac_pkg::MODE_ACTIVE: begin
            if (dang) begin
              ctx_o.alarm_time = item_i.now_ms;
            end else if (since_alarm > gac_pkg::CLEAR_AIR_MS) begin
              ctx_o.confirm_counter = 8'd0;
              ctx_o.mode            = gac_pkg::MODE_IDLE;
            end
          end
          gac_pkg::MODE_SILENCED: begin
            if (crit || (dang && (since_hush >= cfg_i.hush_time_ms))) begin
              ctx_o.mode       = gac_pkg::MODE_ACTIVE;
              ctx_o.alarm_time = item_i.now_ms;
            end else if ((since_hush >= cfg_i.hush_time_ms) || (!dang && !warn)) begin
              ctx_o.mode = gac_pkg::MODE_IDLE;
            end
          end
          gac_pkg::MODE_TEST: begin
            if (item_i.buzzer_finished || (since_test > cfg_i.test_time_ms)) begin
              ctx_o.mode = gac_pkg::MODE_IDLE;
              buz        = gac_pkg::BUZ_OFF;
            end
          end
          default: ;
        endcase
        if ((ctx_o.mode == gac_pkg::MODE_ACTIVE) && (ctx_i.mode != gac_pkg::MODE_ACTIVE)) begin
          buz = gac_pkg::BUZ_ALARM;
        end else if ((ctx_o.mode != gac_pkg::MODE_ACTIVE) &&
                     (ctx_o.mode != gac_pkg::MODE_TEST) &&
                     ((ctx_i.mode == gac_pkg::MODE_ACTIVE) ||
                      (ctx_i.mode == gac_pkg::MODE_TEST))) begin
          buz = gac_pkg::BUZ_OFF;
        end
      end
      gac_pkg::OP_SILENCE: begin
        if (ctx_i.mode == gac_pkg::MODE_ACTIVE) begin
          ctx_o.mode      = gac_pkg::MODE_SILENCED;
          ctx_o.hush_time = item_i.now_ms;
          buz             = gac_pkg::BUZ_OFF;
        end
      end
      gac_pkg::OP_TEST: begin
        ctx_o.mode      = gac_pkg::MODE_TEST;
        ctx_o.test_time = item_i.now_ms;
        buz             = gac_pkg::BUZ_TEST;
      end
      default: ;
    endcase
  end

  assign res_o.alarm_mode     = gac_pkg::mode_code(ctx_o.mode);
  assign res_o.mode_changed   = ctx_o.mode != ctx_i.mode;
  assign res_o.buzzer_command = buz;
  assign res_o.alarm_sounding = (ctx_o.mode == gac_pkg::MODE_ACTIVE) ||
                                (ctx_o.mode == gac_pkg::MODE_TEST);

endmodule

>>> rtl/gas_alarm_controller.sv
// Gas alarm controller top level: config registers, input register, state, result register.
// Depends on gac_pkg, gac_in_if, gac_out_if and gac_step.
// A transaction goes into the input register, its result into the result register.
// One transaction per cycle while out_if is ready, with single input and result registers.
// Reset: state returns to idle with counters and timestamps cleared; config to defaults.
`timescale 1ns / 1ps

module gas_alarm_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  gac_in_if.sink            in_if,
  gac_out_if.source         out_if,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  gac_pkg::cfg_t  cfg_q;
  gac_pkg::item_t in_q;
  gac_pkg::ctx_t  ctx_q;
  gac_pkg::ctx_t  ctx_d;
  gac_pkg::res_t  out_q;
  gac_pkg::res_t  res_d;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           out_free;
  logic           advance;

  assign out_free    = !out_valid_q || out_if.ready;
  assign advance     = in_valid_q && out_free;
  assign in_if.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.co_critical_level <= 16'd400;
      cfg_q.co_alarm_level    <= 16'd100;
      cfg_q.co_warning_level  <= 16'd50;
      cfg_q.voc_alarm_level   <= 9'd400;
      cfg_q.voc_rise_limit    <= 9'd100;
      cfg_q.debounce_count    <= 8'd3;
      cfg_q.hush_time_ms      <= 32'd60000;
      cfg_q.test_time_ms      <= 32'd5000;
    end else if (cfg_we_i) begin
      case (gac_pkg::cfg_idx_e'(cfg_index_i))
        gac_pkg::CFG_CO_CRITICAL: cfg_q.co_critical_level <= cfg_data_i[15:0];
        gac_pkg::CFG_CO_ALARM:    cfg_q.co_alarm_level    <= cfg_data_i[15:0];
        gac_pkg::CFG_CO_WARNING:  cfg_q.co_warning_level  <= cfg_data_i[15:0];
        gac_pkg::CFG_VOC_ALARM:   cfg_q.voc_alarm_level   <= cfg_data_i[8:0];
        gac_pkg::CFG_VOC_RISE:    cfg_q.voc_rise_limit    <= cfg_data_i[8:0];
        gac_pkg::CFG_DEBOUNCE:    cfg_q.debounce_count    <= cfg_data_i[7:0];
        gac_pkg::CFG_HUSH_TIME:   cfg_q.hush_time_ms      <= cfg_data_i;
        gac_pkg::CFG_TEST_TIME:   cfg_q.test_time_ms      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_q.operation       <= in_if.operation;
      in_q.now_ms          <= in_if.now_ms;
      in_q.co_level        <= in_if.co_level;
      in_q.voc_level       <= in_if.voc_level;
      in_q.voc_previous    <= in_if.voc_previous;
      in_q.buzzer_finished <= in_if.buzzer_finished;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.mode            <= gac_pkg::MODE_IDLE;
      ctx_q.confirm_counter <= 8'd0;
      ctx_q.clear_counter   <= 8'd0;
      ctx_q.alarm_time      <= 32'd0;
      ctx_q.hush_time       <= 32'd0;
      ctx_q.test_time       <= 32'd0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  gac_step u_step (
    .cfg_i  (cfg_q),
    .ctx_i  (ctx_q),
    .item_i (in_q),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  assign out_if.valid          = out_valid_q;
  assign out_if.alarm_mode     = out_q.alarm_mode;
  assign out_if.mode_changed   = out_q.mode_changed;
  assign out_if.buzzer_command = out_q.buzzer_command;
  assign out_if.alarm_sounding = out_q.alarm_sounding;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_q))
    else $error("input register lost a pending transaction");

  a_alarm_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.buzzer_command == gac_pkg::BUZ_ALARM) |->
      (ctx_d.mode == gac_pkg::MODE_ACTIVE) && res_d.mode_changed)
    else $error("alarm pattern without entering active state");

  a_test_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.buzzer_command == gac_pkg::BUZ_TEST) |=>
      (ctx_q.mode == gac_pkg::MODE_TEST) && (ctx_q.test_time == $past(in_q.now_ms)))
    else $error("test pattern without test state and timer restart");

  a_state_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(ctx_q))
    else $error("state changed without a transaction");

  a_sounding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.alarm_sounding ==
      ((out_q.alarm_mode == gac_pkg::CODE_ACTIVE) || (out_q.alarm_mode == gac_pkg::CODE_TEST)))
    else $error("sounding flag disagrees with reported mode");

endmodule

>>> dv/tb_gas_alarm_controller.sv
// Self-checking testbench for gas_alarm_controller: directed rows, then random traffic.
// Depends on gac_pkg, gac_in_if, gac_out_if and the controller RTL.
`timescale 1ns / 1ps

module tb_gas_alarm_controller;
  import gac_pkg::*;

  localparam int          DIR_ROWS   = 24;
  localparam int          PHASES     = 6;
  localparam int          CYCLE_CAP  = 400000;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam res_t        NO_RES     = '{CODE_IDLE, 1'b0, BUZ_NONE, 1'b0};

  typedef enum int {
    SK_CLEAR, SK_WARN, SK_DANGER_CO, SK_VOC_HIGH, SK_VOC_RISE, SK_CRITICAL, SK_NOISE
  } sample_kind_e;

  typedef struct packed {
    item_t stim;
    logic  typed;
    res_t  want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  gac_in_if  in_ch ();
  gac_out_if out_ch ();

  gas_alarm_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Alarm mirror: settings and controller state
  cfg_t        alarm_cfg   = '{16'd400, 16'd100, 16'd50, 9'd400, 9'd100, 8'd3,
                               32'd60000, 32'd5000};
  logic [2:0]  st_mode     = CODE_IDLE;
  logic [7:0]  st_confirm  = 8'd0;
  logic [7:0]  st_clear    = 8'd0;
  logic [31:0] st_alarm_ms = 32'd0;
  logic [31:0] st_hush_ms  = 32'd0;
  logic [31:0] st_test_ms  = 32'd0;

  res_t        expected_status_q [$];
  int          mismatch_cnt  = 0;
  int          status_seen   = 0;
  int          items_sent    = 0;
  int          alarm_latches = 0;
  int          cycle_cnt     = 0;
  bit          steady_flow   = 1'b0;

  logic [31:0]  clock_ms    = 32'd200000;
  sample_kind_e streak_kind = SK_CLEAR;
  int           streak_left = 0;
  int           max_streak  = 6;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{OP_UNUSED,  32'd100,        16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_IDLE, 1'b0, BUZ_NONE, 1'b0}},
    '{'{OP_SAMPLE,  32'd1000,       16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_IDLE, 1'b0, BUZ_NONE, 1'b0}},
    '{'{OP_SILENCE, 32'd1100,       16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_IDLE, 1'b0, BUZ_NONE, 1'b0}},
    '{'{OP_SAMPLE,  32'd2000,       16'd60,    9'd10,  9'd10,  1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd3000,       16'd150,   9'd10,  9'd10,  1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd4000,       16'd0,     9'd450, 9'd440, 1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd5000,       16'd0,     9'd300, 9'd150, 1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd20000,      16'd0,     9'd0,   9'd0,   1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd35001,      16'd0,     9'd0,   9'd0,   1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd36000,      16'hFFFF,  9'h1FF, 9'd0,   1'b0}, 1'b1,
      '{CODE_ACTIVE, 1'b1, BUZ_ALARM, 1'b1}},
    '{'{OP_SILENCE, 32'd37000,      16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_SILENCED, 1'b1, BUZ_OFF, 1'b0}},
    '{'{OP_SAMPLE,  32'd40000,      16'd60,    9'd0,   9'd0,   1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd97000,      16'd150,   9'd0,   9'd0,   1'b0}, 1'b0, NO_RES},
    '{'{OP_SILENCE, 32'd98000,      16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_SILENCED, 1'b1, BUZ_OFF, 1'b0}},
    '{'{OP_SAMPLE,  32'd99000,      16'd0,     9'd0,   9'h1FF, 1'b0}, 1'b0, NO_RES},
    '{'{OP_TEST,    32'd100000,     16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_TEST, 1'b1, BUZ_TEST, 1'b1}},
    '{'{OP_TEST,    32'd101000,     16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_TEST, 1'b0, BUZ_TEST, 1'b1}},
    '{'{OP_SAMPLE,  32'd102000,     16'd0,     9'd0,   9'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_TEST,    32'd103000,     16'd0,     9'd0,   9'd0,   1'b0}, 1'b1,
      '{CODE_TEST, 1'b1, BUZ_TEST, 1'b1}},
    '{'{OP_SAMPLE,  32'd108000,     16'd500,   9'd0,   9'd0,   1'b0}, 1'b0, NO_RES},
    '{'{OP_UNUSED,  32'd108500,     16'hFFFF,  9'h1FF, 9'h1FF, 1'b1}, 1'b1,
      '{CODE_TEST, 1'b0, BUZ_NONE, 1'b1}},
    '{'{OP_SAMPLE,  32'd108001,     16'd0,     9'd0,   9'd0,   1'b0}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'hFFFF_FFFF,  16'd399,   9'd399, 9'd0,   1'b1}, 1'b0, NO_RES},
    '{'{OP_SAMPLE,  32'd0,          16'd400,   9'd0,   9'd0,   1'b0}, 1'b0, NO_RES}
  };

  cfg_t phase_cfg [4] = '{
    '{16'd300,  16'd80,   16'd40,   9'd300, 9'd60,  8'd2,  32'd8000,     32'd3000},
    '{16'd0,    16'd0,    16'd0,    9'd0,   9'd0,   8'd0,  32'd0,        32'd0},
    '{16'hFFFF, 16'd200,  16'd20,   9'd350, 9'd80,  8'd0,  32'd1000,     32'd500},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF, 9'h1FF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
  };
  int phase_len [PHASES] = '{150, 80, 100, 350, 100, 100};

  function automatic res_t predict_alarm_step(input item_t it);
    res_t       r;
    logic [2:0] prior;
    logic       danger;
    logic       crit;
    logic       warn;
    buz_e       buz;
    prior  = st_mode;
    buz    = BUZ_NONE;
    crit   = it.co_level >= alarm_cfg.co_critical_level;
    warn   = it.co_level >= alarm_cfg.co_warning_level;
    danger = crit || it.co_level >= alarm_cfg.co_alarm_level ||
             it.voc_level >= alarm_cfg.voc_alarm_level ||
             (it.voc_level >= it.voc_previous &&
              9'(it.voc_level - it.voc_previous) >= alarm_cfg.voc_rise_limit);
    case (it.operation)
      OP_SAMPLE: begin
        if (st_mode == CODE_IDLE || st_mode == CODE_WARNING) begin
          if (danger) begin
            if (crit) begin
              st_mode = CODE_ACTIVE;
              st_alarm_ms = it.now_ms;
              st_confirm = 8'd0;
            end else begin
              st_confirm = (st_confirm == 8'hFF) ? 8'hFF : st_confirm + 8'd1;
              if (st_confirm >= alarm_cfg.debounce_count) begin
                st_mode = CODE_ACTIVE;
                st_alarm_ms = it.now_ms;
                st_confirm = 8'd0;
              end else if (warn) begin
                st_mode = CODE_WARNING;
              end
            end
            st_clear = 8'd0;
          end else begin
            st_confirm = 8'd0;
            if (st_mode == CODE_WARNING) begin
              st_clear = (st_clear == 8'hFF) ? 8'hFF : st_clear + 8'd1;
              if (st_clear >= alarm_cfg.debounce_count) begin
                st_mode = CODE_IDLE;
                st_clear = 8'd0;
              end
            end
          end
        end else if (st_mode == CODE_ACTIVE) begin
          if (!danger) begin
            if (it.now_ms - st_alarm_ms > CLEAR_AIR_MS) begin
              st_confirm = 8'd0;
              st_mode = CODE_IDLE;
            end
          end else begin
            st_alarm_ms = it.now_ms;
          end
        end else if (st_mode == CODE_SILENCED) begin
          if (crit) begin
            st_mode = CODE_ACTIVE;
            st_alarm_ms = it.now_ms;
          end else begin
            if (it.now_ms - st_hush_ms >= alarm_cfg.hush_time_ms) begin
              if (danger) begin
                st_mode = CODE_ACTIVE;
                st_alarm_ms = it.now_ms;
              end else begin
                st_mode = CODE_IDLE;
              end
            end
            if (!danger && !warn) st_mode = CODE_IDLE;
          end
        end else if (st_mode == CODE_TEST) begin
          if (it.buzzer_finished || it.now_ms - st_test_ms > alarm_cfg.test_time_ms) begin
            st_mode = CODE_IDLE;
            buz = BUZ_OFF;
          end
        end
        if (st_mode == CODE_ACTIVE && prior != CODE_ACTIVE) begin
          buz = BUZ_ALARM;
        end else if (st_mode != CODE_ACTIVE && st_mode != CODE_TEST &&
                     (prior == CODE_ACTIVE || prior == CODE_TEST)) begin
          buz = BUZ_OFF;
        end
      end
      OP_SILENCE: begin
        if (st_mode == CODE_ACTIVE) begin
          st_mode = CODE_SILENCED;
          st_hush_ms = it.now_ms;
          buz = BUZ_OFF;
        end
      end
      OP_TEST: begin
        st_mode = CODE_TEST;
        st_test_ms = it.now_ms;
        buz = BUZ_TEST;
      end
      default: ;
    endcase
    r.alarm_mode     = st_mode;
    r.mode_changed   = st_mode != prior;
    r.buzzer_command = buz;
    r.alarm_sounding = st_mode == CODE_ACTIVE || st_mode == CODE_TEST;
    return r;
  endfunction

  function automatic int below(input int lim);
    return (lim <= 0) ? 0 : $urandom_range(0, lim - 1);
  endfunction

  function automatic item_t next_random_item();
    item_t       it;
    int          r;
    int          co;
    int          voc;
    int          prev;
    int          crit;
    int          alm;
    int          wrn;
    int          voc_alm;
    int          rise;
    int          lowest;
    logic [31:0] step;
    crit    = alarm_cfg.co_critical_level;
    alm     = alarm_cfg.co_alarm_level;
    wrn     = alarm_cfg.co_warning_level;
    voc_alm = alarm_cfg.voc_alarm_level;
    rise    = alarm_cfg.voc_rise_limit;
    r = $urandom_range(0, 99);
    if (r < 55)      step = $urandom_range(0, 3000);
    else if (r < 72) step = $urandom_range(3000, 29999);
    else if (r < 80) step = $urandom_range(29995, 30005);
    else if (r < 85) step = alarm_cfg.hush_time_ms + 32'($urandom_range(0, 2)) - 32'd1;
    else if (r < 90) step = alarm_cfg.test_time_ms + 32'($urandom_range(0, 2)) - 32'd1;
    else if (r < 97) step = $urandom_range(30000, 130000);
    else             step = $urandom;
    clock_ms = clock_ms + step;
    it.now_ms          = clock_ms;
    it.buzzer_finished = ($urandom_range(0, 4) == 0);
    lowest = (wrn < alm) ? wrn : alm;
    lowest = (crit < lowest) ? crit : lowest;
    co   = below(lowest);
    voc  = below(voc_alm);
    prev = voc + $urandom_range(0, 40);
    prev = (prev > 511) ? 511 : prev;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.operation = OP_SILENCE;
    end else if (r < 16) begin
      it.operation = OP_TEST;
    end else if (r < 19) begin
      it.operation = OP_UNUSED;
      co   = $urandom_range(0, 65535);
      voc  = $urandom_range(0, 511);
      prev = $urandom_range(0, 511);
    end else begin
      it.operation = OP_SAMPLE;
      if (streak_left == 0) begin
        streak_kind = sample_kind_e'($urandom_range(0, 6));
        streak_left = $urandom_range(1, max_streak);
      end
      streak_left--;
      case (streak_kind)
        SK_WARN: begin
          lowest = (alm < crit) ? alm : crit;
          co = (lowest > wrn) ? $urandom_range(wrn, lowest - 1) : wrn;
        end
        SK_DANGER_CO: co = (crit > alm) ? $urandom_range(alm, crit - 1) : alm;
        SK_VOC_HIGH: begin
          co   = below(wrn);
          voc  = $urandom_range(voc_alm, 511);
          prev = $urandom_range(0, 511);
        end
        SK_VOC_RISE: begin
          co   = below(wrn);
          prev = $urandom_range(0, 511 - rise);
          voc  = $urandom_range(prev + rise, 511);
        end
        SK_CRITICAL: begin
          co   = $urandom_range(crit, 65535);
          voc  = $urandom_range(0, 511);
          prev = $urandom_range(0, 511);
        end
        SK_NOISE: begin
          co   = $urandom_range(0, 65535);
          voc  = $urandom_range(0, 511);
          prev = $urandom_range(0, 511);
        end
        default: ;
      endcase
    end
    it.co_level     = 16'(co);
    it.voc_level    = 9'(voc);
    it.voc_previous = 9'(prev);
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 50) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic send_item(input item_t it, input logic typed, input res_t want);
    int   gap;
    res_t predicted;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= it.operation;
    in_ch.now_ms          <= it.now_ms;
    in_ch.co_level        <= it.co_level;
    in_ch.voc_level       <= it.voc_level;
    in_ch.voc_previous    <= it.voc_previous;
    in_ch.buzzer_finished <= it.buzzer_finished;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = predict_alarm_step(it);
    expected_status_q.push_back(typed ? want : predicted);
    items_sent++;
    if (predicted.buzzer_command == BUZ_ALARM) alarm_latches++;
  endtask

  task automatic settle_results();
    in_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
  endtask

  task automatic program_cfg(input cfg_t c);
    put_reg(CFG_CO_CRITICAL, 32'(c.co_critical_level));
    put_reg(CFG_CO_ALARM,    32'(c.co_alarm_level));
    put_reg(CFG_CO_WARNING,  32'(c.co_warning_level));
    put_reg(CFG_VOC_ALARM,   32'(c.voc_alarm_level));
    put_reg(CFG_VOC_RISE,    32'(c.voc_rise_limit));
    put_reg(CFG_DEBOUNCE,    32'(c.debounce_count));
    put_reg(CFG_HUSH_TIME,   c.hush_time_ms);
    put_reg(CFG_TEST_TIME,   c.test_time_ms);
    cfg_we <= 1'b0;
    alarm_cfg = c;
  endtask

  // Result side: random back-pressure and in-order checking
  initial begin
    int   stall;
    res_t want;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_ch.valid && out_ch.ready) begin
          status_seen++;
          if (expected_status_q.size() == 0) begin
            report_mismatch("status result with nothing expected");
          end else begin
            want = expected_status_q.pop_front();
            if (out_ch.alarm_mode !== want.alarm_mode)
              report_mismatch($sformatf("alarm_mode got %0d want %0d",
                                        out_ch.alarm_mode, want.alarm_mode));
            if (out_ch.mode_changed !== want.mode_changed)
              report_mismatch($sformatf("mode_changed got %0d want %0d",
                                        out_ch.mode_changed, want.mode_changed));
            if (out_ch.buzzer_command !== want.buzzer_command)
              report_mismatch($sformatf("buzzer_command got %0d want %0d",
                                        out_ch.buzzer_command, want.buzzer_command));
            if (out_ch.alarm_sounding !== want.alarm_sounding)
              report_mismatch($sformatf("alarm_sounding got %0d want %0d",
                                        out_ch.alarm_sounding, want.alarm_sounding));
          end
          stall = steady_flow ? 0 : $urandom_range(0, 4);
          out_ch.ready <= (stall == 0);
        end else if (!out_ch.ready) begin
          if (stall > 0) stall--;
          if (stall == 0) out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, expected_status_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    cfg_t c;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_CO_CRITICAL;
    cfg_data              = 32'd0;
    in_ch.valid           = 1'b0;
    in_ch.operation       = OP_SAMPLE;
    in_ch.now_ms          = 32'd0;
    in_ch.co_level        = 16'd0;
    in_ch.voc_level       = 9'd0;
    in_ch.voc_previous    = 9'd0;
    in_ch.buzzer_finished = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_results();
      if (p < 4) begin
        c = phase_cfg[p];
      end else begin
        c.co_critical_level = $urandom_range(0, 1000);
        c.co_alarm_level    = $urandom_range(0, 500);
        c.co_warning_level  = $urandom_range(0, 300);
        c.voc_alarm_level   = $urandom_range(0, 511);
        c.voc_rise_limit    = $urandom_range(0, 200);
        c.debounce_count    = $urandom_range(0, 8);
        c.hush_time_ms      = $urandom_range(0, 100000);
        c.test_time_ms      = $urandom_range(0, 20000);
      end
      program_cfg(c);
      streak_left = 0;
      // hold the VOC alarm long enough to run the confirm counter up to the maximum debounce count
      if (p == 3) begin
        streak_kind = SK_VOC_HIGH;
        streak_left = 260;
      end
      for (int n = 0; n < phase_len[p]; n++) begin
        if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        send_item(next_random_item(), 1'b0, NO_RES);
      end
    end

    settle_results();
    repeat (6) @(posedge clk_i);
    $display("Covered %0d transactions (%0d directed) over %0d register settings, %0d alarms latched.",
             items_sent, DIR_ROWS, PHASES + 1, alarm_latches);
    $display("Checked %0d status results, %0d mismatches.", status_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
